@@ src/acc_step_pkg.sv @@
// ----------------------------------------------------------------------------
// acc_step_pkg
// Shared types and constants for the accelerometer step detector.
// ----------------------------------------------------------------------------
package acc_step_pkg;

    // Field widths
    localparam int ADC_BITS = 12;
    localparam int MAG_W    = 13;
    localparam int STEP_W   = 16;
    localparam int CFG_W    = 7;
    localparam int SUM_W    = 19;
    localparam int THR_W    = 20;

    // Stream data widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((3 * ADC_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((MAG_W + STEP_W + 1 + 7) / 8) * 8;

    localparam int MAX_WINDOW_DEF = 64;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(10);
    localparam logic [CFG_W-1:0] CAL_LEN_RST    = CFG_W'(10);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_CAL_LEN    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } state_t;

endpackage

@@ src/accel_window_step_detector_top.sv @@
// ----------------------------------------------------------------------------
// accel_window_step_detector_top
// Accelerometer magnitude and windowed step detector, bit-serial datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample request (x, y, z); m_* returns one result per
//   sample. cfg_we/cfg_addr/cfg_wdata write window_len (0) and cal_len (1),
//   and the user must do so while the block is idle; it is not enforced.
// Timing:
//   The sum of squares is built by a shift-and-add multiplier, one multiplier
//   bit of each axis per cycle, then a restoring square root takes two
//   radicand bits per cycle, then the finish state updates calibration /
//   window state and loads the output register. A new sample is accepted
//   only once the block is back in idle.
// Reset:
//   rst_n resets all calibration, window and step state; registers return to
//   window_len = 10, cal_len = 10.
// Stall:
//   A new sample is taken while the last result waits in the output register;
//   the finish cycle holds until that register is free.
// ----------------------------------------------------------------------------
module accel_window_step_detector_top
    import acc_step_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [0:0]            cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x, accel_y, accel_z, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // magnitude, step_total, step_seen, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // window_closed
    output logic                  m_tlast,
    // calibrating
    output logic                  m_tuser
);

    localparam int SQ_W   = 2 * ADC_BITS;
    localparam int RAD_W  = SQ_W + 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int PW     = $clog2(MAX_WINDOW + 1);
    localparam int CW     = (PW > CFG_W) ? PW : CFG_W;
    localparam int PROD_W = CFG_W + 1 + MAG_W;

    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(ADC_BITS - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CW-1:0]    WIN_MAX   = CW'(MAX_WINDOW);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CFG_W-1:0]    window_len_reg;
    logic [CFG_W-1:0]    cal_len_reg;

    logic [CNT_W-1:0]    cnt_reg;
    logic [SQ_W-1:0]     mcand_x_reg, mcand_y_reg, mcand_z_reg;
    logic [ADC_BITS-1:0] mplier_x_reg, mplier_y_reg, mplier_z_reg;
    logic [RAD_W-1:0]    acc_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [MAG_W-1:0]    cal_min_reg, cal_max_reg;
    logic [CFG_W-1:0]    cal_seen_reg;
    logic [THR_W-1:0]    step_threshold_reg;
    logic [SUM_W-1:0]    window_sum_reg, previous_sum_reg;
    logic [PW-1:0]       window_pos_reg;
    logic [STEP_W-1:0]   step_count_reg;

    logic                out_valid_reg;
    logic [MAG_W-1:0]    out_mag_reg;
    logic [STEP_W-1:0]   out_steps_reg;
    logic                out_seen_reg, out_closed_reg, out_cal_reg;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic accept, sq_en, root_en, finish, commit, last_iter;

    assign accept = s_tvalid && s_tready;
    assign commit = finish && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                if (cnt_reg == SQ_LAST)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (cnt_reg == ROOT_LAST)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        sq_en     = 1'b0;
        root_en   = 1'b0;
        finish    = 1'b0;
        last_iter = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SQUARE:
            begin
                sq_en     = 1'b1;
                last_iter = (cnt_reg == SQ_LAST);
            end
            ST_ROOT:   root_en = 1'b1;
            ST_FINISH: finish = 1'b1;
            default:   s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            cal_len_reg    <= CAL_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_WINDOW_LEN: window_len_reg <= cfg_wdata;
                REG_CAL_LEN:    cal_len_reg    <= cfg_wdata;
                default:        window_len_reg <= window_len_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bit-serial sum of squares and square root
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]  acc_next;
    logic [REM_W-1:0]  rem_shift, trial, rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        acc_next = acc_reg
                 + (mplier_x_reg[0] ? RAD_W'(mcand_x_reg) : '0)
                 + (mplier_y_reg[0] ? RAD_W'(mcand_y_reg) : '0)
                 + (mplier_z_reg[0] ? RAD_W'(mcand_z_reg) : '0);
    end

    // restoring root: bring in two radicand bits, try (root << 2) | 1
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mcand_x_reg  <= SQ_W'(s_tdata[ADC_BITS-1:0]);
            mcand_y_reg  <= SQ_W'(s_tdata[2*ADC_BITS-1:ADC_BITS]);
            mcand_z_reg  <= SQ_W'(s_tdata[3*ADC_BITS-1:2*ADC_BITS]);
            mplier_x_reg <= s_tdata[ADC_BITS-1:0];
            mplier_y_reg <= s_tdata[2*ADC_BITS-1:ADC_BITS];
            mplier_z_reg <= s_tdata[3*ADC_BITS-1:2*ADC_BITS];
            acc_reg      <= '0;
            rem_reg      <= '0;
            root_reg     <= '0;
            cnt_reg      <= '0;
        end
        else if (sq_en)
        begin
            mcand_x_reg  <= {mcand_x_reg[SQ_W-2:0], 1'b0};
            mcand_y_reg  <= {mcand_y_reg[SQ_W-2:0], 1'b0};
            mcand_z_reg  <= {mcand_z_reg[SQ_W-2:0], 1'b0};
            mplier_x_reg <= {1'b0, mplier_x_reg[ADC_BITS-1:1]};
            mplier_y_reg <= {1'b0, mplier_y_reg[ADC_BITS-1:1]};
            mplier_z_reg <= {1'b0, mplier_z_reg[ADC_BITS-1:1]};
            acc_reg      <= acc_next;
            cnt_reg      <= last_iter ? '0 : cnt_reg + 1'b1;
        end
        else if (root_en)
        begin
            acc_reg  <= {acc_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Calibration and window update
    // ------------------------------------------------------------------
    logic [MAG_W-1:0]  mag;
    logic [CFG_W-1:0]  cal_len_eff;
    logic              cal_phase;
    logic [MAG_W-1:0]  cal_min_next, cal_max_next, cal_diff;
    logic [CFG_W-1:0]  cal_seen_next;
    logic              cal_done;
    logic [PROD_W-1:0] thr_prod;
    logic [THR_W-1:0]  thr_sat;
    logic [CW-1:0]     win_eff, wl_ext;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [PW-1:0]     pos_inc;
    logic              win_closed;
    logic              step_hit;

    assign mag = root_reg[MAG_W-1:0];

    always_comb
    begin
        cal_len_eff   = (cal_len_reg == '0) ? CFG_W'(1) : cal_len_reg;
        cal_phase     = (cal_seen_reg < cal_len_eff);
        cal_min_next  = (mag < cal_min_reg) ? mag : cal_min_reg;
        cal_max_next  = (mag > cal_max_reg) ? mag : cal_max_reg;
        cal_seen_next = cal_seen_reg + 1'b1;
        cal_done      = (cal_seen_next >= cal_len_eff);
        cal_diff      = (cal_max_next >= cal_min_next) ? (cal_max_next - cal_min_next) : '0;
        thr_prod      = PROD_W'({window_len_reg, 1'b0}) * PROD_W'(cal_diff);
        thr_sat       = (thr_prod > PROD_W'(THR_MAX)) ? THR_MAX : thr_prod[THR_W-1:0];

        wl_ext = CW'(window_len_reg);
        if (wl_ext == '0)
            win_eff = CW'(1);
        else if (wl_ext > WIN_MAX)
            win_eff = WIN_MAX;
        else
            win_eff = wl_ext;

        sum_wide   = {1'b0, window_sum_reg} + (SUM_W+1)'(mag);
        sum_sat    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        pos_inc    = window_pos_reg + 1'b1;
        win_closed = (CW'(pos_inc) >= win_eff);
        step_hit   = ((THR_W+1)'(previous_sum_reg)
                      > ((THR_W+1)'(sum_sat) + (THR_W+1)'(step_threshold_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_reg        <= '1;
            cal_max_reg        <= '0;
            cal_seen_reg       <= '0;
            step_threshold_reg <= '0;
            window_sum_reg     <= '0;
            previous_sum_reg   <= '0;
            window_pos_reg     <= '0;
            step_count_reg     <= '0;
        end
        else if (commit)
        begin
            if (cal_phase)
            begin
                cal_min_reg  <= cal_min_next;
                cal_max_reg  <= cal_max_next;
                cal_seen_reg <= cal_seen_next;
                if (cal_done)
                    step_threshold_reg <= thr_sat;
            end
            else if (win_closed)
            begin
                if (step_hit)
                    step_count_reg <= step_count_reg + 1'b1;
                previous_sum_reg <= sum_sat;
                window_sum_reg   <= '0;
                window_pos_reg   <= '0;
            end
            else
            begin
                window_sum_reg <= sum_sat;
                window_pos_reg <= pos_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_mag_reg    <= mag;
            out_cal_reg    <= cal_phase;
            out_closed_reg <= !cal_phase && win_closed;
            out_seen_reg   <= !cal_phase && win_closed && step_hit;
            out_steps_reg  <= (!cal_phase && win_closed && step_hit)
                              ? step_count_reg + 1'b1 : step_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_seen_reg, out_steps_reg, out_mag_reg});
    assign m_tlast  = out_closed_reg;
    assign m_tuser  = out_cal_reg;

endmodule
